@@ design/websocket_frame_deframer_defines.svh @@
// ---------------------------------------------------------------------------
// websocket_frame_deframer_defines
// Assertion macros used by the deframer parser module (wsd_parse).
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, clocked on i_clk, idle in reset
`define WSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wsd assertion failed");

// next-cycle implication
`define WSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wsd assertion failed");

`endif

@@ design/wsd_pkg.sv @@
// ---------------------------------------------------------------------------
// wsd_pkg
// Types and constants of the frame deframer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsd_pkg;

    localparam int LEN_W   = 64;
    localparam int BYTE_W  = 8;
    localparam int TDATA_W = 88;

    localparam logic [6:0] LEN16_CODE = 7'd126;
    localparam logic [6:0] LEN64_CODE = 7'd127;
    localparam logic [2:0] EXT16_CNT  = 3'd1;
    localparam logic [2:0] EXT64_CNT  = 3'd7;
    localparam logic [1:0] KEY_LAST   = 2'd3;

    localparam logic KIND_HDR  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef enum logic [4:0] {
        PH_B0   = 5'b00001,
        PH_B1   = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_DATA = 5'b10000
    } t_phase;

    typedef struct packed {
        logic              kind;
        logic              fin;
        logic [2:0]        rsv;
        logic [3:0]        opcode;
        logic              masked;
        logic [LEN_W-1:0]  payload_len;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } t_result;

endpackage

@@ design/wsd_in_reg.sv @@
// ---------------------------------------------------------------------------
// wsd_in_reg
// Input register: holds one received byte until the parser takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsd_in_reg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_valid,
    output logic                      o_s_ready,
    input  logic [wsd_pkg::BYTE_W-1:0] i_s_byte,
    input  logic                      i_take,
    output logic                      o_valid,
    output logic [wsd_pkg::BYTE_W-1:0] o_byte
);

    logic                       r_valid;
    logic                       n_valid;
    logic [wsd_pkg::BYTE_W-1:0] r_byte;
    logic                       w_load;

    assign o_s_ready = !r_valid || i_take;
    assign w_load    = i_s_valid && o_s_ready;
    assign n_valid   = w_load || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_s_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

@@ design/wsd_parse.sv @@
// ---------------------------------------------------------------------------
// wsd_parse
// Header parser and payload unmasker; one byte per taken beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "websocket_frame_deframer_defines.svh"

module wsd_parse (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [wsd_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_room,
    output logic                       o_take,
    output logic                       o_res_valid,
    output wsd_pkg::t_result           o_res
);

    wsd_pkg::t_phase           r_phase,  n_phase;
    logic [2:0]                r_ext,    n_ext;
    logic [1:0]                r_kcnt,   n_kcnt;
    logic                      r_fin,    n_fin;
    logic [2:0]                r_rsv,    n_rsv;
    logic [3:0]                r_opc,    n_opc;
    logic                      r_masked, n_masked;
    logic [wsd_pkg::LEN_W-1:0] r_len,    n_len;
    logic [31:0]               r_key,    n_key;
    logic [wsd_pkg::LEN_W-1:0] r_rem,    n_rem;
    logic [1:0]                r_kidx,   n_kidx;

    logic                       w_hdr_done;
    logic                       w_res_valid;
    logic [wsd_pkg::LEN_W-1:0]  w_rem_dec;
    logic [wsd_pkg::BYTE_W-1:0] w_kb;
    logic                       w_last;
    logic [6:0]                 w_len7;
    wsd_pkg::t_result           w_res;

    always_comb begin
        n_phase     = r_phase;
        n_ext       = r_ext;
        n_kcnt      = r_kcnt;
        n_fin       = r_fin;
        n_rsv       = r_rsv;
        n_opc       = r_opc;
        n_masked    = r_masked;
        n_len       = r_len;
        n_key       = r_key;
        n_rem       = r_rem;
        n_kidx      = r_kidx;
        w_hdr_done  = 1'b0;
        w_res_valid = 1'b0;
        w_res       = '0;
        w_len7      = i_byte[6:0];
        w_rem_dec   = r_rem - {{(wsd_pkg::LEN_W-1){1'b0}}, 1'b1};
        w_kb        = r_masked ? r_key[{~r_kidx, 3'b000} +: 8] : '0;
        w_last      = 1'b0;

        case (r_phase)
            wsd_pkg::PH_B1: begin
                n_masked = i_byte[7];
                n_kcnt   = '0;
                n_key    = '0;
                if (w_len7 == wsd_pkg::LEN16_CODE) begin
                    n_len   = '0;
                    n_ext   = wsd_pkg::EXT16_CNT;
                    n_phase = wsd_pkg::PH_EXT;
                end else if (w_len7 == wsd_pkg::LEN64_CODE) begin
                    n_len   = '0;
                    n_ext   = wsd_pkg::EXT64_CNT;
                    n_phase = wsd_pkg::PH_EXT;
                end else begin
                    n_len = {{(wsd_pkg::LEN_W-7){1'b0}}, w_len7};
                    if (i_byte[7]) begin
                        n_phase = wsd_pkg::PH_KEY;
                    end else begin
                        w_hdr_done = 1'b1;
                    end
                end
            end
            wsd_pkg::PH_EXT: begin
                n_len = {r_len[wsd_pkg::LEN_W-9:0], i_byte};
                if (r_ext != 3'd0) begin
                    n_ext = r_ext - 3'd1;
                end else if (r_masked) begin
                    n_phase = wsd_pkg::PH_KEY;
                end else begin
                    w_hdr_done = 1'b1;
                end
            end
            wsd_pkg::PH_KEY: begin
                n_key = {r_key[23:0], i_byte};
                if (r_kcnt != wsd_pkg::KEY_LAST) begin
                    n_kcnt = r_kcnt + 2'd1;
                end else begin
                    n_kcnt     = '0;
                    w_hdr_done = 1'b1;
                end
            end
            wsd_pkg::PH_DATA: begin
                n_kidx = r_kidx + 2'd1;
                n_rem  = w_rem_dec;
                w_last = (w_rem_dec == '0);
                if (w_last) begin
                    n_phase = wsd_pkg::PH_B0;
                end
                w_res_valid       = 1'b1;
                w_res.kind        = wsd_pkg::KIND_DATA;
                w_res.fin         = r_fin;
                w_res.rsv         = r_rsv;
                w_res.opcode      = r_opc;
                w_res.masked      = r_masked;
                w_res.payload_len = r_len;
                w_res.data_byte   = i_byte ^ w_kb;
                w_res.last        = w_last;
            end
            default: begin
                n_fin   = i_byte[7];
                n_rsv   = i_byte[6:4];
                n_opc   = i_byte[3:0];
                n_phase = wsd_pkg::PH_B1;
            end
        endcase

        if (w_hdr_done) begin
            n_rem             = n_len;
            n_kidx            = '0;
            n_phase           = (n_len == '0) ? wsd_pkg::PH_B0 : wsd_pkg::PH_DATA;
            w_res_valid       = 1'b1;
            w_res.kind        = wsd_pkg::KIND_HDR;
            w_res.fin         = n_fin;
            w_res.rsv         = n_rsv;
            w_res.opcode      = n_opc;
            w_res.masked      = n_masked;
            w_res.payload_len = n_len;
            w_res.data_byte   = '0;
            w_res.last        = (n_len == '0);
        end
    end

    assign o_take      = i_valid && (i_room || !w_res_valid);
    assign o_res_valid = o_take && w_res_valid;
    assign o_res       = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsd_pkg::PH_B0;
            r_ext    <= '0;
            r_kcnt   <= '0;
            r_fin    <= 1'b0;
            r_rsv    <= '0;
            r_opc    <= '0;
            r_masked <= 1'b0;
            r_len    <= '0;
            r_key    <= '0;
            r_rem    <= '0;
            r_kidx   <= '0;
        end else if (o_take) begin
            r_phase  <= n_phase;
            r_ext    <= n_ext;
            r_kcnt   <= n_kcnt;
            r_fin    <= n_fin;
            r_rsv    <= n_rsv;
            r_opc    <= n_opc;
            r_masked <= n_masked;
            r_len    <= n_len;
            r_key    <= n_key;
            r_rem    <= n_rem;
            r_kidx   <= n_kidx;
        end
    end

    `WSD_ASSERT_NEXT(a_last_rearms, o_res_valid && o_res.last, r_phase == wsd_pkg::PH_B0)
    `WSD_ASSERT_NEXT(a_hdr_to_data, o_res_valid && (o_res.kind == wsd_pkg::KIND_HDR) && !o_res.last, r_phase == wsd_pkg::PH_DATA && r_kidx == 2'd0)
    `WSD_ASSERT_NOW(a_hdr_no_data, o_res_valid && (o_res.kind == wsd_pkg::KIND_HDR), o_res.data_byte == '0)
    `WSD_ASSERT_NOW(a_data_phase, o_res_valid && (o_res.kind == wsd_pkg::KIND_DATA), r_phase == wsd_pkg::PH_DATA)

endmodule

@@ design/wsd_out_reg.sv @@
// ---------------------------------------------------------------------------
// wsd_out_reg
// Result register: holds one result beat for the downstream side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsd_out_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  wsd_pkg::t_result            i_res,
    output logic                        o_room,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [wsd_pkg::TDATA_W-1:0] o_m_tdata,
    output logic                        o_m_tuser,
    output logic                        o_m_tlast
);

    logic             r_valid;
    logic             n_valid;
    wsd_pkg::t_result r_res;

    assign o_room  = !r_valid || i_m_tready;
    assign n_valid = i_load || (r_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_res.kind;
    assign o_m_tlast  = r_res.last;
    assign o_m_tdata  = {7'd0, r_res.data_byte, r_res.payload_len, r_res.masked,
                         r_res.opcode, r_res.rsv, r_res.fin};

endmodule

@@ design/websocket_frame_deframer.sv @@
// ---------------------------------------------------------------------------
// websocket_frame_deframer
// Frame header parser and payload unmasker for a received byte stream.
// ---------------------------------------------------------------------------
//  channel  dir  beat contents
//  s_axis   in   tdata[7:0] in_byte
//  m_axis   out  tdata: fin, rsv, opcode, masked, payload_len, data_byte;
//                tuser: kind; tlast: last
//
//  One byte per cycle sustained while m_axis does not stall; an input beat
//  passes the input register, then the parser, into the result register.
//  Header bytes before the last one give no result beat.
//  Synchronous active-low reset returns the parser to the first header byte.
//  A stalled m_axis still passes header bytes that give no result; s_axis
//  stalls once a result-making byte waits in the input register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module websocket_frame_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,   // [7:0] in_byte
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [0] fin, [3:1] rsv, [7:4] opcode, [8] masked, [72:9] payload_len,
    // [80:73] data_byte, [87:81] zero
    output logic [wsd_pkg::TDATA_W-1:0] o_m_axis_tdata,
    output logic                        o_m_axis_tuser,   // [0] kind
    output logic                        o_m_axis_tlast
);

    logic                       w_in_valid;
    logic [wsd_pkg::BYTE_W-1:0] w_in_byte;
    logic                       w_take;
    logic                       w_room;
    logic                       w_res_valid;
    wsd_pkg::t_result           w_res;

    wsd_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_s_byte  (i_s_axis_tdata),
        .i_take    (w_take),
        .o_valid   (w_in_valid),
        .o_byte    (w_in_byte)
    );

    wsd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_in_valid),
        .i_byte      (w_in_byte),
        .i_room      (w_room),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    wsd_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_res_valid),
        .i_res      (w_res),
        .o_room     (w_room),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser),
        .o_m_tlast  (o_m_axis_tlast)
    );

endmodule
